// ===== sv/dfc_pkg.sv =====
// shared types and constants of the distance fade controller
package dfc_pkg;

  localparam int DIST_BITS  = 32;
  localparam int NOW_BITS   = 48;
  localparam int CFG_BITS   = 32;
  localparam int PHASE_BITS = 3;
  localparam int LEVEL_BITS = 5;
  localparam int ADDR_BITS  = 4;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_MIN_DIST = 2'd0;
  localparam logic [1:0] REG_MAX_DIST = 2'd1;
  localparam logic [1:0] REG_STEP_US  = 2'd2;

  localparam logic [CFG_BITS-1:0] MIN_DIST_RESET = 32'd0;
  localparam logic [CFG_BITS-1:0] MAX_DIST_RESET = 32'hFFFF_FFFF;
  localparam logic [CFG_BITS-1:0] STEP_US_RESET  = 32'd27777;

  localparam logic [LEVEL_BITS-1:0] LVL_HIDDEN    = 5'd0;
  localparam logic [LEVEL_BITS-1:0] LVL_FIRST_IN  = 5'd1;
  localparam logic [LEVEL_BITS-1:0] LVL_FIRST_OUT = 5'd16;
  localparam logic [LEVEL_BITS-1:0] LVL_SHOWN     = 5'd17;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_INITIAL  = 3'd0,
    PH_OUT      = 3'd1,
    PH_FADE_IN  = 3'd2,
    PH_IN       = 3'd3,
    PH_FADE_OUT = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] min_dist_sq;
    logic [CFG_BITS-1:0] max_dist_sq;
    logic [CFG_BITS-1:0] fade_step_us;
  } cfg_t;

endpackage

// ===== sv/dfc_if.sv =====
// valid/ready channel interfaces for items and results
interface dfc_in_if;
  import dfc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [DIST_BITS-1:0]  distance_sq;
  logic [NOW_BITS-1:0]   now_us;

  modport source (output valid, distance_sq, now_us, input ready);
  modport sink   (input valid, distance_sq, now_us, output ready);
endinterface

interface dfc_out_if;
  import dfc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PHASE_BITS-1:0] phase;
  logic [LEVEL_BITS-1:0] fade_level;

  modport source (output valid, phase, fade_level, input ready);
  modport sink   (input valid, phase, fade_level, output ready);
endinterface

// ===== sv/dfc_cfg_regs.sv =====
// apb configuration register file
module dfc_cfg_regs
  import dfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [CFG_BITS-1:0]  pwdata,
  output logic [CFG_BITS-1:0]  prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_dist_sq  <= MIN_DIST_RESET;
      cfg.max_dist_sq  <= MAX_DIST_RESET;
      cfg.fade_step_us <= STEP_US_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_DIST: cfg.min_dist_sq  <= pwdata;
        REG_MAX_DIST: cfg.max_dist_sq  <= pwdata;
        REG_STEP_US:  cfg.fade_step_us <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_DIST: prdata = cfg.min_dist_sq;
      REG_MAX_DIST: prdata = cfg.max_dist_sq;
      REG_STEP_US:  prdata = cfg.fade_step_us;
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== sv/dfc_fade_fsm.sv =====
// fade state machine: phase, level and next step deadline
module dfc_fade_fsm
  import dfc_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step_en,
  input  logic [DIST_BITS-1:0]  distance_sq,
  input  logic [NOW_BITS-1:0]   now_us,
  input  cfg_t                  cfg,
  output phase_t                phase,
  output logic [LEVEL_BITS-1:0] level
);

  phase_t                 phase_next;
  logic [LEVEL_BITS-1:0]  level_next;
  logic [TIME_BITS-1:0]   next_step_time;
  logic [TIME_BITS-1:0]   next_step_time_next;
  logic [TIME_BITS-1:0]   now_t;
  logic [TIME_BITS:0]     dl_sum;
  logic [TIME_BITS-1:0]   deadline;
  logic                   in_band;
  logic                   due;

  // time taken modulo 2^TIME_BITS
  assign now_t = TIME_BITS'(now_us);

  // deadline saturates at all ones, never wraps
  assign dl_sum   = {1'b0, now_t} + (TIME_BITS + 1)'(cfg.fade_step_us);
  assign deadline = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

  assign in_band = (distance_sq >= cfg.min_dist_sq) && (distance_sq <= cfg.max_dist_sq);
  assign due     = now_t >= next_step_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_INITIAL;
      level          <= LVL_HIDDEN;
      next_step_time <= '0;
    end else if (step_en) begin
      phase          <= phase_next;
      level          <= level_next;
      next_step_time <= next_step_time_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    level_next          = level;
    next_step_time_next = next_step_time;
    unique case (phase)
      PH_OUT: begin
        if (in_band) begin
          phase_next          = PH_FADE_IN;
          level_next          = LVL_FIRST_IN;
          next_step_time_next = deadline;
        end
      end
      PH_FADE_IN: begin
        if (!in_band) begin
          phase_next          = PH_FADE_OUT;
          next_step_time_next = deadline;
        end else if (due) begin
          if (level >= LVL_FIRST_OUT) begin
            phase_next = PH_IN;
            level_next = LVL_SHOWN;
          end else begin
            level_next          = level + LVL_FIRST_IN;
            next_step_time_next = deadline;
          end
        end
      end
      PH_IN: begin
        if (!in_band) begin
          phase_next          = PH_FADE_OUT;
          level_next          = LVL_FIRST_OUT;
          next_step_time_next = deadline;
        end
      end
      PH_FADE_OUT: begin
        if (in_band) begin
          phase_next          = PH_FADE_IN;
          next_step_time_next = deadline;
        end else if (due) begin
          if (level <= LVL_FIRST_IN) begin
            phase_next = PH_OUT;
            level_next = LVL_HIDDEN;
          end else begin
            level_next          = level - LVL_FIRST_IN;
            next_step_time_next = deadline;
          end
        end
      end
      default: begin
        phase_next = in_band ? PH_IN : PH_OUT;
        level_next = in_band ? LVL_SHOWN : LVL_HIDDEN;
      end
    endcase
  end

  a_in_full: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IN |-> level == LVL_SHOWN)
    else $error("in phase without full level");

  a_out_hidden: assert property (@(posedge clk) disable iff (rst)
    phase == PH_OUT |-> level == LVL_HIDDEN)
    else $error("out phase without hidden level");

  a_fade_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FADE_IN || phase == PH_FADE_OUT)
      |-> (level >= LVL_FIRST_IN && level <= LVL_FIRST_OUT))
    else $error("fade level out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step_en |=> $stable(phase) && $stable(level))
    else $error("state moved without an item");

endmodule

// ===== sv/distance_fade_controller.sv =====
// top level of the distance-driven visibility fade controller
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+----------------------------------------
//  in_ch    | in  | valid / ready   | distance_sq[31:0], now_us[47:0]
//  out_ch   | out | valid / ready   | phase[2:0], fade_level[4:0]
//  apb      | in  | psel / penable  | paddr[3:0], pwdata / prdata[31:0]
//
//  an item is registered on transfer, and its result is loaded into the state
//  registers, which also drive the result payload, once the result slot is free
//  one item per cycle is sustained while out_ch does not stall; result valid
//  is registered together with the state registers, so the result passes the
//  input register and the state register before it can transfer
//  stalls on out_ch hold the item in the input register, and in_ch stays
//  ready while that register is empty or being emptied in the same cycle
//  rst is synchronous, active high: empty pipeline, initial phase, level 0,
//  registers at their reset values
module distance_fade_controller
  import dfc_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  dfc_in_if.sink               in_ch,
  dfc_out_if.source            out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [CFG_BITS-1:0]  pwdata,
  output logic [CFG_BITS-1:0]  prdata,
  output logic                 pready
);

  cfg_t                  cfg;
  phase_t                phase;
  logic [LEVEL_BITS-1:0] level;

  // input register
  logic                  in_vld;
  logic [DIST_BITS-1:0]  in_dist;
  logic [NOW_BITS-1:0]   in_now;

  // result valid; payload lives in the state machine registers
  logic                  out_vld;
  logic                  advance;

  dfc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the item in the input register moves on once the result slot is free
  // or is being taken in this cycle
  assign advance     = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
  end

  // payload needs no reset, only loaded on transfer
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_dist <= in_ch.distance_sq;
      in_now  <= in_ch.now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  dfc_fade_fsm #(
    .TIME_BITS (TIME_BITS)
  ) u_fsm (
    .clk         (clk),
    .rst         (rst),
    .step_en     (advance),
    .distance_sq (in_dist),
    .now_us      (in_now),
    .cfg         (cfg),
    .phase       (phase),
    .level       (level)
  );

  assign out_ch.valid      = out_vld;
  assign out_ch.phase      = phase;
  assign out_ch.fade_level = level;

  a_adv_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_vld)
    else $error("result not presented after state update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_ch.ready |-> !advance)
    else $error("pending result overwritten");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_vld && !advance |=> in_vld)
    else $error("held item dropped");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the distance fade controller
`timescale 1ns / 100ps

module testbench;
  import dfc_pkg::*;

  localparam logic [NOW_BITS-1:0] TIME_MAX = '1;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_AT_RESULT = 150; // result count that starts the long sink hold-off
  localparam int HOLD_CYCLES = 60;
  localparam int QUIET_FROM = 250;     // transfer window with no idling on either side
  localparam int QUIET_TO = 330;

  typedef struct {
    logic [DIST_BITS-1:0] distance_sq;
    logic [NOW_BITS-1:0]  now_us;
  } fade_item_t;

  typedef struct {
    phase_t                phase;
    logic [LEVEL_BITS-1:0] fade_level;
  } look_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [CFG_BITS-1:0]  pwdata;
  logic [CFG_BITS-1:0]  prdata;
  logic                 pready;

  dfc_in_if  in_ch ();
  dfc_out_if out_ch ();

  distance_fade_controller uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // items waiting for the driver, and looks predicted for items already transferred
  fade_item_t pending_items[$];
  look_t      expected_looks[$];

  int sent_count = 0;
  int got_count = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // mirror of the configuration registers
  logic [CFG_BITS-1:0] band_lo = MIN_DIST_RESET;
  logic [CFG_BITS-1:0] band_hi = MAX_DIST_RESET;
  logic [CFG_BITS-1:0] step_us = STEP_US_RESET;

  // mirror of the fade state
  phase_t                fade_phase = PH_INITIAL;
  logic [LEVEL_BITS-1:0] fade_lvl = LVL_HIDDEN;
  logic [NOW_BITS-1:0]   due_us = '0;

  // next step deadline; saturates at the top of the time range rather than wrapping
  function automatic logic [NOW_BITS-1:0] deadline_after(logic [NOW_BITS-1:0] now);
    logic [NOW_BITS:0] sum;
    sum = {1'b0, now} + {{(NOW_BITS + 1 - CFG_BITS){1'b0}}, step_us};
    return sum[NOW_BITS] ? TIME_MAX : sum[NOW_BITS-1:0];
  endfunction

  // moves the mirrored fade state on by one item and returns the look after the update
  function automatic look_t advance_fade(logic [DIST_BITS-1:0] d, logic [NOW_BITS-1:0] now);
    bit    in_band;
    look_t res;
    in_band = (d >= band_lo) && (d <= band_hi);
    case (fade_phase)
      PH_OUT: begin
        if (in_band) begin
          fade_phase = PH_FADE_IN;
          due_us = deadline_after(now);
          fade_lvl = LVL_FIRST_IN;
        end
      end
      PH_FADE_IN: begin
        if (!in_band) begin
          // reversal keeps the level
          fade_phase = PH_FADE_OUT;
          due_us = deadline_after(now);
        end else if (now >= due_us) begin
          if (fade_lvl >= LVL_SHOWN - 1) begin
            // fully shown, deadline left as it was
            fade_lvl = LVL_SHOWN;
            fade_phase = PH_IN;
          end else begin
            fade_lvl = fade_lvl + 1'b1;
            due_us = deadline_after(now);
          end
        end
      end
      PH_IN: begin
        if (!in_band) begin
          fade_phase = PH_FADE_OUT;
          due_us = deadline_after(now);
          fade_lvl = LVL_FIRST_OUT;
        end
      end
      PH_FADE_OUT: begin
        if (in_band) begin
          fade_phase = PH_FADE_IN;
          due_us = deadline_after(now);
        end else if (now >= due_us) begin
          if (fade_lvl <= LVL_FIRST_IN) begin
            fade_lvl = LVL_HIDDEN;
            fade_phase = PH_OUT;
          end else begin
            fade_lvl = fade_lvl - 1'b1;
            due_us = deadline_after(now);
          end
        end
      end
      default: begin
        // first item: straight to fully shown or fully hidden
        fade_phase = in_band ? PH_IN : PH_OUT;
        fade_lvl = in_band ? LVL_SHOWN : LVL_HIDDEN;
      end
    endcase
    res.phase = fade_phase;
    res.fade_level = fade_lvl;
    return res;
  endfunction

  // distance inside or outside the current band, leaning towards the band edges
  function automatic logic [DIST_BITS-1:0] pick_distance(bit want_in);
    bit lo_room;
    bit hi_room;
    lo_room = band_lo != '0;
    hi_room = band_hi != '1;
    if (want_in && band_lo <= band_hi) begin
      case ($urandom_range(0, 4))
        0: return band_lo;
        1: return band_hi;
        default: return $urandom_range(band_lo, band_hi);
      endcase
    end
    if (lo_room && (!hi_room || $urandom_range(0, 1) == 1)) begin
      return ($urandom_range(0, 3) == 0) ? band_lo - 1'b1 : $urandom_range(0, band_lo - 1'b1);
    end
    if (hi_room) begin
      return ($urandom_range(0, 3) == 0) ? band_hi + 1'b1
                                         : $urandom_range(band_hi + 1'b1, 32'hFFFF_FFFF);
    end
    return $urandom;
  endfunction

  // driver: keeps in_ch offered from the item queue, predicting each transfer as it happens
  always @(posedge clk) begin : driver
    fade_item_t nxt;
    bit         give;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_looks = {expected_looks, advance_fade(in_ch.distance_sq, in_ch.now_us)};
        sent_count++;
      end
      // a held item stays put until it is taken
      if (!in_ch.valid || in_ch.ready) begin
        give = pending_items.size() != 0 &&
               ((sent_count >= QUIET_FROM && sent_count < QUIET_TO) ||
                $urandom_range(0, 99) >= 13);
        if (give) begin
          nxt = pending_items.pop_front();
          in_ch.distance_sq <= nxt.distance_sq;
          in_ch.now_us <= nxt.now_us;
        end
        in_ch.valid <= give;
      end
    end
  end

  // monitor: checks every result transfer against the oldest prediction and throttles out_ch
  always @(posedge clk) begin : monitor
    look_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_looks.size() == 0) begin
          $error("unexpected result: phase %0d fade_level %0d", out_ch.phase, out_ch.fade_level);
          error_count++;
        end else begin
          want = expected_looks.pop_front();
          if (out_ch.phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, out_ch.phase);
            error_count++;
          end
          if (out_ch.fade_level !== want.fade_level) begin
            $error("fade_level: expected %0d, actual %0d", want.fade_level, out_ch.fade_level);
            error_count++;
          end
        end
        got_count++;
      end
      // one long hold-off mid-run so the block fills and back-pressures in_ch
      if (!hold_done && got_count == HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (got_count >= QUIET_FROM && got_count < QUIET_TO) ||
                        $urandom_range(0, 99) >= 13;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // settles at the falling edge so every update of the rising edge is visible
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_looks.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // only called with the block idle
  task automatic load_config(logic [CFG_BITS-1:0] lo, logic [CFG_BITS-1:0] hi,
                             logic [CFG_BITS-1:0] step);
    write_reg(REG_MIN_DIST, lo);
    band_lo = lo;
    write_reg(REG_MAX_DIST, hi);
    band_hi = hi;
    write_reg(REG_STEP_US, step);
    step_us = step;
  endtask

  task automatic add_item(logic [DIST_BITS-1:0] d, logic [NOW_BITS-1:0] now);
    pending_items = {pending_items, fade_item_t'{d, now}};
  endtask

  initial begin : stimulus
    logic [CFG_BITS-1:0] lo;
    logic [CFG_BITS-1:0] hi;
    logic [CFG_BITS-1:0] step;
    logic [NOW_BITS-1:0] track_us;
    logic [NOW_BITS:0]   sum;
    logic [63:0]         wide;
    bit                  want_in;

    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset band is open on both ends: first item jumps straight to fully shown
    add_item(32'd0, 48'd0);
    add_item(32'hFFFF_FFFF, TIME_MAX);
    wait_idle();

    // fade out, mid-fade reversal, fade in to the end, time running backwards
    load_config(32'd1000, 32'd5000, 32'd10);
    add_item(32'd0, 48'd200);
    add_item(32'd0, 48'd205);
    add_item(32'd0, 48'd210);
    add_item(32'd1000, 48'd215);
    add_item(32'd5000, 48'd225);
    add_item(32'd5000, 48'd235);
    add_item(32'd5001, 48'd240);
    add_item(32'd999, 48'd100);
    add_item(32'd3000, 48'd300);
    add_item(32'd3000, 48'd310);
    wait_idle();

    // zero step interval: a step on every item while fading
    load_config(32'd1000, 32'd5000, 32'd0);
    add_item(32'd6000, 48'd0);
    add_item(32'd6000, 48'd0);
    add_item(32'd6000, 48'd0);
    add_item(32'd4000, 48'd0);
    add_item(32'd4000, 48'd0);
    wait_idle();

    // empty band with the widest step: deadline saturates at the top of time
    load_config(32'd5000, 32'd1000, 32'hFFFF_FFFF);
    add_item(32'd3000, 48'hFFFF_FFFF_0000);
    add_item(32'd3000, 48'hFFFF_FFFF_FFFE);
    add_item(32'd3000, TIME_MAX);
    add_item(32'h8000_0000, TIME_MAX);
    wait_idle();

    // random phases: time runs forward on a track at about one step per item,
    // distance stays in or out of band for a while so fades can finish
    for (int ph = 0; ph < 8; ph++) begin
      wide = {$urandom, $urandom};
      track_us = wide[NOW_BITS-1:0] >> $urandom_range(8, 47);
      case (ph)
        0: begin
          lo = '0;
          hi = $urandom;
          step = $urandom_range(1, 20);
        end
        1: begin
          lo = $urandom;
          hi = '1;
          step = $urandom_range(0, 8);
        end
        2: begin
          // band of a single value
          lo = $urandom;
          hi = lo;
          step = 32'd5;
        end
        3: begin
          // empty band
          hi = $urandom_range(0, 32'h7FFF_FFFF);
          lo = hi + $urandom_range(1, 32'h7FFF_FFFF);
          step = $urandom_range(0, 12);
        end
        4: begin
          // widest step near the top of time
          lo = $urandom_range(0, 32'h7FFF_FFFF);
          hi = lo + $urandom_range(0, 32'h7FFF_FFFF);
          step = '1;
          track_us = 48'hFFF0_0000_0000 + 48'($urandom);
        end
        5: begin
          lo = '0;
          hi = '1;
          step = '0;
        end
        default: begin
          lo = $urandom_range(0, 32'h7FFF_FFFF);
          hi = lo + $urandom_range(0, 32'h7FFF_FFFF);
          step = $urandom_range(0, 30);
        end
      endcase
      load_config(lo, hi, step);
      want_in = $urandom_range(0, 1);
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 11) == 0) want_in = !want_in;
        sum = {1'b0, track_us} + NOW_BITS'($urandom_range(0, step)) +
              NOW_BITS'($urandom_range(0, step));
        track_us = sum[NOW_BITS] ? TIME_MAX : sum[NOW_BITS-1:0];
        // a little noise: stray distances and stray times
        if ($urandom_range(0, 99) < 3) begin
          wide = {$urandom, $urandom};
          add_item($urandom, wide[NOW_BITS-1:0]);
        end else if ($urandom_range(0, 99) < 8) begin
          add_item($urandom, track_us);
        end else begin
          add_item(pick_distance(want_in), track_us);
        end
      end
      wait_idle();
    end

    // let any stray result show up before the verdict
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
